FILE: rtl/double_precision_multiplier_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary64 multiplier
// Shared concurrent-assertion helpers.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_PRECISION_MULTIPLIER_DEFINES_SVH
`define DOUBLE_PRECISION_MULTIPLIER_DEFINES_SVH

// Implication checked on every edge outside reset.
`define DPM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the following cycle.
`define DPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/dpm_pkg.sv
// ----------------------------------------------------------------------------
// dpm_pkg
// Binary64 field widths, constants and request classes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpm_pkg;

   localparam int WordWidth = 64;
   localparam int ExpWidth  = 11;
   localparam int MantWidth = 52;
   localparam int SigWidth  = 53;
   localparam int ProdWidth = 106;
   localparam logic [ExpWidth-1:0] ExpMax = 11'h7FF;

   typedef logic [WordWidth-1:0] word_type;

   // outcome of the special-case screen
   typedef enum logic [2:0] {
      CLS_NUMBER,
      CLS_PASS_A,
      CLS_PASS_B,
      CLS_INVALID,
      CLS_ZERO,
      CLS_INF
   } class_type;

endpackage

FILE: rtl/double_precision_multiplier.sv
// ----------------------------------------------------------------------------
// double_precision_multiplier
// Pipelined binary64 multiplier, round half-up on one guard bit.
// ----------------------------------------------------------------------------
//  channel | ports                        | direction
//  --------+------------------------------+-----------
//  request | req_valid req_stall          | in
//          | req_operand_a req_operand_b  |
//  result  | rsp_valid rsp_stall rsp_product | out
//
// Five register stages; one request per cycle unless the output is stalled.
// Stage 1: decode, special screen, four partial products of 27/26-bit parts.
// Stage 2: partial product sum (106 bit). Stage 3: leading-one count.
// Stage 4: normalizing shift, exponent. Stage 5: round and pack.
// The whole pipe advances when the output stage is empty or taken; a
// stall freezes every stage, so nothing is lost or repeated.
// Reset (synchronous, active high) clears only the valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "double_precision_multiplier_defines.svh"

module double_precision_multiplier (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  dpm_pkg::word_type      req_operand_a,
   input  dpm_pkg::word_type      req_operand_b,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dpm_pkg::word_type      rsp_product
);
   import dpm_pkg::*;

   localparam int Stages = 5;

   logic [Stages-1:0] vld_ff, vld_in;
   logic              adv;

   assign adv       = !(vld_ff[Stages-1] && rsp_stall);
   assign req_stall = !adv;

   always_comb begin
      vld_in = {vld_ff[Stages-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------- stage 1: decode and partial products ----------------
   logic [ExpWidth-1:0]  ea, eb;
   logic [MantWidth-1:0] ma, mb;
   logic [SigWidth-1:0]  sa, sb;
   logic                 a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
   class_type            cls_in;
   logic                 sub_in;
   logic signed [13:0]   ebase_in;

   assign ea = req_operand_a[62:52];
   assign eb = req_operand_b[62:52];
   assign ma = req_operand_a[51:0];
   assign mb = req_operand_b[51:0];
   assign a_zero = (ea == '0) && (ma == '0);
   assign b_zero = (eb == '0) && (mb == '0);
   assign a_inf  = (ea == ExpMax) && (ma == '0);
   assign b_inf  = (eb == ExpMax) && (mb == '0);
   assign a_nan  = (ea == ExpMax) && (ma != '0);
   assign b_nan  = (eb == ExpMax) && (mb != '0);
   // subnormal operand has no hidden bit
   assign sa = {(ea != '0), ma};
   assign sb = {(eb != '0), mb};

   always_comb begin
      if (b_nan)                                  cls_in = CLS_PASS_B;
      else if (a_nan)                             cls_in = CLS_PASS_A;
      else if ((a_zero && b_inf) || (b_zero && a_inf)) cls_in = CLS_INVALID;
      else if (a_zero || b_zero || (ea == '0 && eb == '0)) cls_in = CLS_ZERO;
      else if (a_inf || b_inf)                    cls_in = CLS_INF;
      else                                        cls_in = CLS_NUMBER;
   end

   assign sub_in = (ea == '0) || (eb == '0);
   // exponent before normalization: leading one at 104 means ea+eb-1023;
   // subnormal path uses enorm-1022 (ea/eb=0 contributes zero)
   assign ebase_in = sub_in ? (14'(ea) + 14'(eb) - 14'sd1022)
                            : (14'(ea) + 14'(eb) - 14'sd1023);

   logic [26:0] al, bl;
   logic [25:0] ah, bh;
   assign al = sa[26:0];
   assign ah = sa[52:27];
   assign bl = sb[26:0];
   assign bh = sb[52:27];

   logic [53:0] pll_ff;
   logic [52:0] plh_ff, phl_ff;
   logic [51:0] phh_ff;
   class_type   cls1_ff;
   logic        sub1_ff, sgn1_ff;
   logic signed [13:0] eb1_ff;
   word_type    pass1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pll_ff   <= al * bl;
         plh_ff   <= al * bh;
         phl_ff   <= 53'(ah * bl);
         phh_ff   <= ah * bh;
         cls1_ff  <= cls_in;
         sub1_ff  <= sub_in;
         sgn1_ff  <= req_operand_a[63] ^ req_operand_b[63];
         eb1_ff   <= ebase_in;
         pass1_ff <= b_nan ? req_operand_b : req_operand_a;
      end
   end

   // ---------------- stage 2: sum partial products ----------------
   logic [ProdWidth-1:0] prod2_ff;
   class_type   cls2_ff;
   logic        sub2_ff, sgn2_ff;
   logic signed [13:0] eb2_ff;
   word_type    pass2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         prod2_ff <= ProdWidth'(pll_ff) + (ProdWidth'(plh_ff) << 27)
                   + (ProdWidth'(phl_ff) << 27) + (ProdWidth'(phh_ff) << 54);
         cls2_ff  <= cls1_ff;
         sub2_ff  <= sub1_ff;
         sgn2_ff  <= sgn1_ff;
         eb2_ff   <= eb1_ff;
         pass2_ff <= pass1_ff;
      end
   end

   // ---------------- stage 3: leading-one position ----------------
   logic [6:0] top_in;
   always_comb begin
      top_in = '0;
      for (int i = 0; i < ProdWidth; i++) begin
         if (prod2_ff[i]) top_in = 7'(i);
      end
   end

   logic [ProdWidth-1:0] prod3_ff;
   logic [6:0]  top3_ff;
   class_type   cls3_ff;
   logic        sub3_ff, sgn3_ff;
   logic signed [13:0] eb3_ff;
   word_type    pass3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         prod3_ff <= prod2_ff;
         top3_ff  <= top_in;
         cls3_ff  <= cls2_ff;
         sub3_ff  <= sub2_ff;
         sgn3_ff  <= sgn2_ff;
         eb3_ff   <= eb2_ff;
         pass3_ff <= pass2_ff;
      end
   end

   // ---------------- stage 4: normalize ----------------
   // normal path: top is 104 or 105, shift right by carry.
   // subnormal path: shift left so the top lands on 104.
   logic [ProdWidth-1:0] norm_in;
   logic signed [13:0]   e_in;
   logic [6:0]           lsh;
   assign lsh = 7'd104 - top3_ff;

   always_comb begin
      if (sub3_ff) begin
         norm_in = prod3_ff << lsh;
         e_in    = eb3_ff - 14'(lsh);
      end else begin
         norm_in = prod3_ff[105] ? (prod3_ff >> 1) : prod3_ff;
         e_in    = eb3_ff + 14'(prod3_ff[105]);
      end
   end

   logic [53:0] m4_ff;        // bits 104..51 of normalized product
   logic signed [13:0] e4_ff;
   class_type   cls4_ff;
   logic        sgn4_ff;
   word_type    pass4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m4_ff    <= norm_in[104:51];
         e4_ff    <= e_in;
         cls4_ff  <= cls3_ff;
         sgn4_ff  <= sgn3_ff;
         pass4_ff <= pass3_ff;
      end
   end

   // ---------------- stage 5: round and pack ----------------
   word_type   res_in;
   logic [53:0] r, msh;
   logic [5:0]  dsh;
   logic signed [13:0] en;

   always_comb begin
      r      = '0;
      msh    = '0;
      en     = e4_ff;
      dsh    = 6'(7'sd1 - e4_ff);
      res_in = {sgn4_ff, 63'd0};
      case (cls4_ff)
         CLS_PASS_A, CLS_PASS_B: res_in = pass4_ff;
         CLS_INVALID: res_in = {sgn4_ff, ExpMax, 52'd1};
         CLS_ZERO:    res_in = {sgn4_ff, 63'd0};
         CLS_INF:     res_in = {sgn4_ff, ExpMax, 52'd0};
         CLS_NUMBER: begin
            if (e4_ff >= 14'sd2047) begin
               res_in = {sgn4_ff, ExpMax, 52'd0};
            end else if (e4_ff > 14'sd0) begin
               r = {1'b0, m4_ff[53:1]} + 54'(m4_ff[0]);
               if (r[53]) begin
                  r  = r >> 1;
                  en = e4_ff + 14'sd1;
               end
               if (en >= 14'sd2047) res_in = {sgn4_ff, ExpMax, 52'd0};
               else res_in = {sgn4_ff, en[10:0], r[51:0]};
            end else if (e4_ff >= -14'sd52) begin
               // total shift 52-e from bit 51; here 1-e on top of that
               msh    = m4_ff >> dsh;
               r      = {1'b0, msh[53:1]} + 54'(msh[0]);
               res_in = {sgn4_ff, 10'd0, r[52], r[51:0]};
            end else begin
               res_in = {sgn4_ff, 63'd0};
            end
         end
         default: res_in = {sgn4_ff, 63'd0};
      endcase
   end

   word_type out_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= res_in;
      end
   end

   assign rsp_valid   = vld_ff[Stages-1];
   assign rsp_product = out_ff;

   `DPM_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_product), "held result changed")
   `DPM_ASSERT_IMP(a_stall, clock, reset, req_stall, rsp_valid && rsp_stall, "stall without cause")
   `DPM_ASSERT_IMP(a_norm, clock, reset, vld_ff[3] && cls4_ff == CLS_NUMBER && e4_ff > -14'sd60, m4_ff[53], "product not normalized")

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binary64 multiplier: a directed table of
// special operands, then random operand pairs from assorted classes under
// varied idling, checked against typed-in or bit-exact predicted products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import dpm_pkg::*;

   localparam int      NumRandom = 1100;
   localparam int      Latency   = 5;
   localparam word_type PosInf   = 64'h7FF0_0000_0000_0000;
   localparam word_type NegInf   = 64'hFFF0_0000_0000_0000;
   localparam word_type PosZero  = 64'h0;
   localparam word_type NegZero  = 64'h8000_0000_0000_0000;
   localparam word_type InvalidP = 64'h7FF0_0000_0000_0001;
   localparam word_type One      = 64'h3FF0_0000_0000_0000;
   localparam word_type MaxNorm  = 64'h7FEF_FFFF_FFFF_FFFF;
   localparam word_type MinNorm  = 64'h0010_0000_0000_0000;
   localparam word_type MinSub   = 64'h0000_0000_0000_0001;
   localparam word_type MaxSub   = 64'h000F_FFFF_FFFF_FFFF;
   localparam word_type QNan     = 64'h7FF8_0000_0000_0000;
   localparam word_type SNanNeg  = 64'hFFF0_0000_DEAD_BEEF;

   logic     clock, reset;
   logic     req_valid, req_stall;
   word_type req_operand_a, req_operand_b;
   logic     rsp_valid, rsp_stall;
   word_type rsp_product;

   double_precision_multiplier dut (.*);

   word_type expected_products[$];
   int       errors;
   int       send_idle_pct, recv_stall_pct;

   // directed table: operands, and a typed-in product where it is obvious
   typedef struct {
      word_type a;
      word_type b;
      bit       known;
      word_type p;
   } vector_type;

   vector_type directed[] = '{
      '{One,      One,      1, One},
      '{QNan,     One,      1, QNan},
      '{One,      SNanNeg,  1, SNanNeg},
      '{QNan,     SNanNeg,  1, SNanNeg},       // second NaN wins
      '{PosZero,  PosInf,   1, InvalidP},      // zero times infinity
      '{NegInf,   PosZero,  1, 64'hFFF0_0000_0000_0001},
      '{NegZero,  One,      1, NegZero},
      '{PosZero,  MaxNorm,  1, PosZero},
      '{PosInf,   MinSub,   1, PosInf},        // infinity times subnormal
      '{NegInf,   NegInf,   1, PosInf},
      '{PosInf,   NegZero ^ One, 1, NegInf},
      '{MaxSub,   MinSub,   1, PosZero},       // subnormal pair flushes
      '{MaxNorm,  MaxNorm,  1, PosInf},        // exponent overflow
      '{MinNorm,  MinNorm,  1, PosZero},       // deep underflow
      '{MinNorm,  64'h3FE0_0000_0000_0000, 0, 0}, // into subnormal range
      '{MinSub,   One,      1, MinSub},
      '{MaxSub,   64'h4000_0000_0000_0000, 0, 0},
      '{64'h7FE0_0000_0000_0000, 64'h4000_0000_0000_0000, 1, PosInf},
      '{64'h3FF0_0000_0000_0001, 64'h3FEF_FFFF_FFFF_FFFF, 0, 0}, // rounding
      '{64'h3FFF_FFFF_FFFF_FFFF, 64'h3FFF_FFFF_FFFF_FFFF, 0, 0},
      '{64'h7FEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0001, 0, 0}, // round to inf
      '{64'h000F_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0001, 0, 0}, // to min normal
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 1, 64'h7FFF_FFFF_FFFF_FFFF}
   };

   // bit-exact product: special screen, exact significand product,
   // normalize to bit 104, round half-up on one guard bit, pack
   function automatic word_type predict_product(word_type a, word_type b);
      logic [10:0]  ea, eb;
      logic [51:0]  ma, mb;
      logic         sgn, a_zero, b_zero, a_inf, b_inf;
      logic [105:0] prod;
      logic [54:0]  m, r;
      int           e, top, sh;
      ea = a[62:52];  eb = b[62:52];
      ma = a[51:0];   mb = b[51:0];
      sgn = a[63] ^ b[63];
      a_zero = (a[62:0] == 0);  b_zero = (b[62:0] == 0);
      a_inf = (ea == ExpMax) && (ma == 0);
      b_inf = (eb == ExpMax) && (mb == 0);
      if (eb == ExpMax && mb != 0) return b;
      if (ea == ExpMax && ma != 0) return a;
      if ((a_zero && b_inf) || (b_zero && a_inf)) return {sgn, ExpMax, 52'd1};
      if (a_zero || b_zero || (ea == 0 && eb == 0)) return {sgn, 63'd0};
      if (a_inf || b_inf) return {sgn, ExpMax, 52'd0};
      if (ea == 0 || eb == 0) begin
         if (ea == 0) prod = 106'(ma) * 106'({1'b1, mb});
         else         prod = 106'(mb) * 106'({1'b1, ma});
         top = 0;
         for (int i = 0; i < 106; i++) if (prod[i]) top = i;
         sh = 104 - top;
         prod = prod << sh;
         e = int'(ea == 0 ? eb : ea) - 1022 - sh;
      end else begin
         prod = 106'({1'b1, ma}) * 106'({1'b1, mb});
         e = int'(ea) + int'(eb) - 1023 + int'(prod[105]);
         if (prod[105]) prod = prod >> 1;
      end
      if (e >= 2047) return {sgn, ExpMax, 52'd0};
      if (e > 0) begin
         m = 55'(prod >> 51);
         r = (m >> 1) + 55'(m[0]);
         if (r[53]) begin
            r = r >> 1;
            e++;
         end
         if (e >= 2047) return {sgn, ExpMax, 52'd0};
         return {sgn, 11'(e), r[51:0]};
      end
      if (e >= -52) begin
         m = 55'(prod >> (52 - e));
         r = (m >> 1) + 55'(m[0]);
         return {sgn, 10'd0, r[52], r[51:0]};
      end
      return {sgn, 63'd0};
   endfunction

   // operand drawn from a mix of classes so every path is well exercised
   function automatic word_type random_operand();
      word_type w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 11))
         0:       w[62:52] = 11'd0;                              // subnormal
         1:       w[62:52] = ExpMax;                             // inf / NaN
         2:       w[62:0]  = {ExpMax, 52'd0};                    // infinity
         3:       w[62:0]  = 63'd0;                              // zero
         4:       w[62:52] = 11'($urandom_range(1, 40));         // tiny
         5:       w[62:52] = 11'($urandom_range(2000, 2046));    // huge
         6:       w[62:52] = 11'($urandom_range(480, 560));      // product near min
         7:       w[51:0]  = {52{1'b1}} ^ 52'($urandom_range(0, 3)); // round carry
         8:       w[62:52] = 11'($urandom_range(1000, 1050));
         9:       w[62:52] = 11'($urandom_range(1, 2046));
         default: ;
      endcase
      return w;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("** double_precision_multiplier: FAILED **");
      $finish;
   end

   // checker: compare each accepted product with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_products.size() == 0) begin
            $error("unexpected product %h", rsp_product);
            errors++;
         end else begin
            word_type want;
            want = expected_products.pop_front();
            if (rsp_product !== want) begin
               $error("product: expected %h actual %h", want, rsp_product);
               errors++;
            end
         end
      end
   end

   // receiver stall, random per phase
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // send one request, honoring sender idling; returns after acceptance
   task automatic send_request(word_type a, word_type b, bit known, word_type p);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_products.push_back(known ? p : predict_product(a, b));
   endtask

   initial begin
      int phase;
      errors = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operand_a = '0;
      req_operand_b = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_request(directed[i].a, directed[i].b, directed[i].known, directed[i].p);

      // idling phases: none, sender, receiver, both, none
      for (int n = 0; n < NumRandom; n++) begin
         phase = (n * 5) / NumRandom;
         case (phase)
            0, 4: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:    begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2:    begin send_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase
         send_request(random_operand(), random_operand(), 0, '0);
      end
      req_valid <= 1'b0;
      recv_stall_pct = 0;

      while (expected_products.size() != 0) @(posedge clock);
      repeat (Latency * 4) @(posedge clock);
      if (errors == 0)
         $display("** double_precision_multiplier: PASSED **");
      else
         $display("** double_precision_multiplier: FAILED **");
      $finish;
   end

endmodule

FILE: double_precision_multiplier.f
+incdir+rtl
rtl/dpm_pkg.sv
rtl/double_precision_multiplier.sv
verif/tb.sv
